// File: src/tgc_pkg.sv
// Package: shared constants, types and font tables of the glyph column generator.
package tgc_pkg;

  localparam int unsigned DISPLAY_WIDTH = 128;
  localparam int unsigned PAGE_COUNT    = 8;

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned COL_W   = 8;
  localparam int unsigned PAGE_W  = 3;
  localparam int unsigned ADDR_W  = 7;
  localparam int unsigned BYTE_W  = 8;

  localparam int unsigned FONT_SIZE   = 44;
  localparam int unsigned IDX_W       = $clog2(FONT_SIZE);
  localparam int unsigned QMARK_INDEX = 17;
  localparam int unsigned GLYPH_COLS  = 5;
  localparam int unsigned LARGE_COLS  = 7;
  localparam int unsigned SMALL_CELL  = 6;
  localparam int unsigned LARGE_CELL  = 8;
  localparam int unsigned CASE_SHIFT  = 32;

  // Write counter: sixteen writes for a large cell, six for a small one.
  localparam int unsigned CNT_W       = 4;
  localparam logic [CNT_W-1:0] SMALL_LAST = CNT_W'(SMALL_CELL - 1);
  localparam logic [CNT_W-1:0] LARGE_LAST = CNT_W'(2 * LARGE_CELL - 1);

  // Range checks use one bit more than a column so the sum cannot wrap.
  localparam int unsigned SUM_W = COL_W + 1;

  typedef logic [0:GLYPH_COLS-1][BYTE_W-1:0] glyph_t;

  // Font index of a character already folded to upper case.
  function automatic logic [IDX_W-1:0] font_index(input logic [CODE_W-1:0] code);
    logic [IDX_W-1:0] idx;
    idx = IDX_W'(QMARK_INDEX);
    if (code >= 8'h30 && code <= 8'h39) begin
      idx = IDX_W'(code - 8'h30 + 8'd6);
    end else if (code >= 8'h41 && code <= 8'h5A) begin
      idx = IDX_W'(code - 8'h41 + 8'd18);
    end else begin
      case (code)
        8'h20:   idx = IDX_W'(0);
        8'h28:   idx = IDX_W'(1);
        8'h29:   idx = IDX_W'(2);
        8'h2D:   idx = IDX_W'(3);
        8'h2E:   idx = IDX_W'(4);
        8'h2F:   idx = IDX_W'(5);
        8'h3A:   idx = IDX_W'(16);
        default: idx = IDX_W'(QMARK_INDEX);
      endcase
    end
    return idx;
  endfunction

  // Five columns of a 5x7 glyph, bit 0 is the top pixel.
  function automatic glyph_t glyph_bits(input logic [IDX_W-1:0] idx);
    glyph_t g;
    unique case (idx)
      6'd0:    g = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      6'd1:    g = {8'h00, 8'h1C, 8'h22, 8'h41, 8'h00};
      6'd2:    g = {8'h00, 8'h41, 8'h22, 8'h1C, 8'h00};
      6'd3:    g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      6'd4:    g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
      6'd5:    g = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02};
      6'd6:    g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      6'd7:    g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      6'd8:    g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      6'd9:    g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      6'd10:   g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      6'd11:   g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      6'd12:   g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      6'd13:   g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      6'd14:   g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      6'd15:   g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      6'd16:   g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
      6'd17:   g = {8'h02, 8'h01, 8'h51, 8'h09, 8'h06};
      6'd18:   g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
      6'd19:   g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
      6'd20:   g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
      6'd21:   g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
      6'd22:   g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
      6'd23:   g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
      6'd24:   g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
      6'd25:   g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      6'd26:   g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      6'd27:   g = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
      6'd28:   g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
      6'd29:   g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
      6'd30:   g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      6'd31:   g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
      6'd32:   g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      6'd33:   g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
      6'd34:   g = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
      6'd35:   g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
      6'd36:   g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
      6'd37:   g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      6'd38:   g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      6'd39:   g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      6'd40:   g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
      6'd41:   g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      6'd42:   g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
      6'd43:   g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
      default: g = {8'h02, 8'h01, 8'h51, 8'h09, 8'h06};
    endcase
    return g;
  endfunction

  // Source glyph column of large column i, that is i*5/7.
  function automatic logic [2:0] large_src_col(input logic [2:0] i);
    logic [2:0] s;
    unique case (i)
      3'd0, 3'd1: s = 3'd0;
      3'd2:       s = 3'd1;
      3'd3, 3'd4: s = 3'd2;
      3'd5:       s = 3'd3;
      default:    s = 3'd4;
    endcase
    return s;
  endfunction

  // Doubles pixel r onto pixels 2r+1 and 2r+2; top and bottom stay blank.
  function automatic logic [2*BYTE_W-1:0] stretch_column(input logic [BYTE_W-1:0] bits);
    logic [2*BYTE_W-1:0] acc;
    acc = '0;
    for (int r = 0; r < 7; r++) begin
      acc[2*r+1] = bits[r];
      acc[2*r+2] = bits[r];
    end
    return acc;
  endfunction

endpackage

// File: src/tgc_in_if.sv
// Interface: character input channel with valid/ready handshake.
interface tgc_in_if;
  logic                         valid;
  logic                         ready;
  logic [tgc_pkg::CODE_W-1:0]   char_code;
  logic [tgc_pkg::ROW_W-1:0]    text_row;
  logic [tgc_pkg::COL_W-1:0]    start_col;
  logic                         large_mode;
  logic                         invert;

  modport source (output valid, char_code, text_row, start_col, large_mode, invert,
                  input ready);
  modport sink   (input valid, char_code, text_row, start_col, large_mode, invert,
                  output ready);
endinterface

// File: src/tgc_out_if.sv
// Interface: framebuffer byte write channel with valid/ready handshake.
interface tgc_out_if;
  logic                         valid;
  logic                         ready;
  logic [tgc_pkg::PAGE_W-1:0]   page_addr;
  logic [tgc_pkg::ADDR_W-1:0]   col_addr;
  logic [tgc_pkg::BYTE_W-1:0]   pixel_byte;
  logic                         last_write;

  modport source (output valid, page_addr, col_addr, pixel_byte, last_write,
                  input ready);
  modport sink   (input valid, page_addr, col_addr, pixel_byte, last_write,
                  output ready);
endinterface

// File: src/text_glyph_column_generator_core.sv
// Top level: character to framebuffer byte write generator with a 5x7 font.
//
//   Channel  Direction  Word                                      Handshake
//   in_i     sink       char_code, text_row, start_col, large,    valid/ready
//                       invert
//   out_o    source     page_addr, col_addr, pixel_byte,          valid/ready
//                       last_write
//
// A character passes three register stages (check and case fold, font index,
// glyph columns) and then sits in the write sequencer, which emits one byte
// write per cycle into the output register while the output is not stalled:
// six writes for a small cell, sixteen for a large one. Characters that are
// out of range are accepted and dropped in the first stage. Reset clears every
// valid bit; payload registers are not reset. Each stage advances only when
// the one after it is free or is emptying, so a stall on the output holds all
// stages in place and nothing is lost.
module text_glyph_column_generator_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  tgc_in_if.sink    in_i,
  tgc_out_if.source out_o
);

  // Stage 1: range check and case fold.
  logic                           s1_valid_q;
  logic [tgc_pkg::CODE_W-1:0]     s1_code_q;
  logic [tgc_pkg::ROW_W-1:0]      s1_row_q;
  logic [tgc_pkg::COL_W-1:0]      s1_col_q;
  logic                           s1_large_q;
  logic                           s1_inv_q;

  // Stage 2: font index.
  logic                           s2_valid_q;
  logic [tgc_pkg::IDX_W-1:0]      s2_idx_q;
  logic [tgc_pkg::ROW_W-1:0]      s2_row_q;
  logic [tgc_pkg::COL_W-1:0]      s2_col_q;
  logic                           s2_large_q;
  logic                           s2_inv_q;

  // Stage 3: glyph columns.
  logic                           s3_valid_q;
  tgc_pkg::glyph_t                s3_glyph_q;
  logic [tgc_pkg::ROW_W-1:0]      s3_row_q;
  logic [tgc_pkg::COL_W-1:0]      s3_col_q;
  logic                           s3_large_q;
  logic                           s3_inv_q;

  // Stage 4: write sequencer holding the character being drawn.
  logic                           s4_valid_q;
  tgc_pkg::glyph_t                s4_glyph_q;
  logic [tgc_pkg::ROW_W-1:0]      s4_row_q;
  logic [tgc_pkg::COL_W-1:0]      s4_col_q;
  logic                           s4_large_q;
  logic                           s4_inv_q;
  logic [tgc_pkg::CNT_W-1:0]      cnt_q, cnt_d;

  // Output register.
  logic                           out_valid_q;
  logic [tgc_pkg::PAGE_W-1:0]     out_page_q;
  logic [tgc_pkg::ADDR_W-1:0]     out_col_q;
  logic [tgc_pkg::BYTE_W-1:0]     out_byte_q;
  logic                           out_last_q;

  // Flow control: a stage may load when it is empty or is handing on its word.
  logic out_free, emit, emit_last;
  logic s4_load, s3_load, s2_load, s1_load;
  logic s4_free, s3_free, s2_free, s1_free;

  assign out_free = !out_valid_q || out_o.ready;
  assign emit     = s4_valid_q && out_free;
  assign s4_free  = !s4_valid_q || (emit && emit_last);
  assign s3_free  = !s3_valid_q || s4_free;
  assign s2_free  = !s2_valid_q || s3_free;
  assign s1_free  = !s1_valid_q || s2_free;

  assign s4_load  = s4_free;
  assign s3_load  = s3_free;
  assign s2_load  = s2_free;
  assign s1_load  = s1_free;

  assign in_i.ready = s1_free;

  // Input check: row in range and the whole cell inside the display.
  logic                         in_fire, in_ok;
  logic [tgc_pkg::SUM_W-1:0]    in_end;
  logic [tgc_pkg::CODE_W-1:0]   in_fold;

  always_comb begin
    in_fire = in_i.valid && in_i.ready;
    if (in_i.large_mode) begin
      in_end = {1'b0, in_i.start_col} + tgc_pkg::SUM_W'(tgc_pkg::LARGE_CELL);
      in_ok  = (in_i.text_row < tgc_pkg::ROW_W'(tgc_pkg::PAGE_COUNT / 2)) &&
               (in_end <= tgc_pkg::SUM_W'(tgc_pkg::DISPLAY_WIDTH));
    end else begin
      in_end = {1'b0, in_i.start_col} + tgc_pkg::SUM_W'(tgc_pkg::SMALL_CELL);
      in_ok  = (in_i.text_row < tgc_pkg::ROW_W'(tgc_pkg::PAGE_COUNT)) &&
               (in_end <= tgc_pkg::SUM_W'(tgc_pkg::DISPLAY_WIDTH));
    end
    // Lower case letters share the upper case glyphs.
    if (in_i.char_code >= 8'h61 && in_i.char_code <= 8'h7A) begin
      in_fold = in_i.char_code - tgc_pkg::CODE_W'(tgc_pkg::CASE_SHIFT);
    end else begin
      in_fold = in_i.char_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s1_load) s1_valid_q <= in_fire && in_ok;
      if (s2_load) s2_valid_q <= s1_valid_q;
      if (s3_load) s3_valid_q <= s2_valid_q;
      if (s4_load) s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_code_q  <= in_fold;
      s1_row_q   <= in_i.text_row;
      s1_col_q   <= in_i.start_col;
      s1_large_q <= in_i.large_mode;
      s1_inv_q   <= in_i.invert;
    end
    if (s2_load) begin
      s2_idx_q   <= tgc_pkg::font_index(s1_code_q);
      s2_row_q   <= s1_row_q;
      s2_col_q   <= s1_col_q;
      s2_large_q <= s1_large_q;
      s2_inv_q   <= s1_inv_q;
    end
    if (s3_load) begin
      s3_glyph_q <= tgc_pkg::glyph_bits(s2_idx_q);
      s3_row_q   <= s2_row_q;
      s3_col_q   <= s2_col_q;
      s3_large_q <= s2_large_q;
      s3_inv_q   <= s2_inv_q;
    end
    if (s4_load) begin
      s4_glyph_q <= s3_glyph_q;
      s4_row_q   <= s3_row_q;
      s4_col_q   <= s3_col_q;
      s4_large_q <= s3_large_q;
      s4_inv_q   <= s3_inv_q;
    end
  end

  // Write sequencer. In large mode the counter's low bit picks the upper or
  // lower page and the rest picks the column; column seven is the spacing.
  logic [2:0]                     col_ofs;
  logic                           half;
  logic [2*tgc_pkg::BYTE_W-1:0]   tall;
  logic [tgc_pkg::BYTE_W-1:0]     inv_mask, wr_byte;
  logic [tgc_pkg::SUM_W-1:0]      wr_col, wr_page;

  always_comb begin
    inv_mask = s4_inv_q ? '1 : '0;
    half     = cnt_q[0];
    tall     = '0;
    if (s4_large_q) begin
      col_ofs   = cnt_q[3:1];
      emit_last = (cnt_q == tgc_pkg::LARGE_LAST);
      wr_page   = {s4_row_q, 1'b0} + tgc_pkg::SUM_W'(half);
      if (col_ofs == 3'(tgc_pkg::LARGE_COLS)) begin
        wr_byte = inv_mask;
      end else begin
        tall    = tgc_pkg::stretch_column(s4_glyph_q[tgc_pkg::large_src_col(col_ofs)]);
        wr_byte = (half ? tall[2*tgc_pkg::BYTE_W-1:tgc_pkg::BYTE_W]
                        : tall[tgc_pkg::BYTE_W-1:0]) ^ inv_mask;
      end
    end else begin
      col_ofs   = cnt_q[2:0];
      emit_last = (cnt_q == tgc_pkg::SMALL_LAST);
      wr_page   = {1'b0, s4_row_q};
      if (col_ofs >= 3'(tgc_pkg::GLYPH_COLS)) begin
        wr_byte = inv_mask;
      end else begin
        wr_byte = s4_glyph_q[col_ofs] ^ inv_mask;
      end
    end
    wr_col = {1'b0, s4_col_q} + tgc_pkg::SUM_W'(col_ofs);

    cnt_d = cnt_q;
    if (emit) begin
      cnt_d = emit_last ? '0 : cnt_q + tgc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (out_free) out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_page_q <= wr_page[tgc_pkg::PAGE_W-1:0];
      out_col_q  <= wr_col[tgc_pkg::ADDR_W-1:0];
      out_byte_q <= wr_byte;
      out_last_q <= emit_last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.page_addr  = out_page_q;
  assign out_o.col_addr   = out_col_q;
  assign out_o.pixel_byte = out_byte_q;
  assign out_o.last_write = out_last_q;

  // The counter never passes the last write of a small cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q && !s4_large_q |-> cnt_q <= tgc_pkg::SMALL_LAST)
    else $error("small cell write counter overran");

  // The final write of every character is a spacing byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last_write |-> out_o.pixel_byte == 8'h00 || out_o.pixel_byte == 8'hFF)
    else $error("last write is not a spacing byte");

  // The counter only leaves zero while a character is being drawn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s4_valid_q |-> cnt_q == '0)
    else $error("write counter busy without a character");

  // A write taken while the sequencer is idle leaves the output empty next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !s4_valid_q |=> !out_o.valid)
    else $error("output word appeared without a source");

endmodule
